### src/overwrite_ring_queue_with_mean_macros.svh
// Assertion macros shared by the queue RTL.
// Both expect a signal named clock in the including scope; ORQM_ASSERT also expects reset.
`ifndef OVERWRITE_RING_QUEUE_WITH_MEAN_MACROS_SVH
`define OVERWRITE_RING_QUEUE_WITH_MEAN_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset
`define ORQM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define ORQM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ORQM_ASSERT(lbl, prop, msg)
`define ORQM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### src/orqm_pkg.sv
`default_nettype none

package orqm_pkg;

   // Queue geometry
   localparam int DEPTH  = 8;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths
   localparam int TAG_W  = 32;
   localparam int YEAR_W = 16;
   localparam int OCC_W  = 4;

   // Running sum holds up to DEPTH years of magnitude 2^15
   localparam int SUM_W  = YEAR_W + 1 + $clog2(DEPTH);
   // Divider: numerator 2*|sum| + n, denominator 2*n
   localparam int NUM_W  = SUM_W + 1;
   localparam int DEN_W  = CNT_W + 1;
   localparam int ITER_W = $clog2(NUM_W + 1);

   // Command codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      KIND_MEAN    = 2'd0,
      KIND_REMOVED = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     action;
      logic [TAG_W-1:0]         record_tag;
      logic signed [YEAR_W-1:0] birth_year;
   } req_type;

   typedef struct packed {
      kind_type                 result_kind;
      logic signed [YEAR_W-1:0] mean_year;
      logic                     evicted;
      logic [TAG_W-1:0]         removed_tag;
      logic signed [YEAR_W-1:0] removed_year;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [YEAR_W-1:0] year;
   } entry_type;

   // Ring pointer advance with wrap at DEPTH
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/orqm_store.sv
`default_nettype none

module orqm_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [orqm_pkg::PTR_W-1:0] wr_addr,
   input  wire orqm_pkg::entry_type       wr_data,
   input  wire logic                      rd_en,
   input  wire logic [orqm_pkg::PTR_W-1:0] rd_addr,
   output      orqm_pkg::entry_type       rd_data
);
   import orqm_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/orqm_div.sv
`default_nettype none

module orqm_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [orqm_pkg::NUM_W-1:0] num,
   input  wire logic [orqm_pkg::DEN_W-1:0] den,
   output      logic                       done,
   output      logic [orqm_pkg::NUM_W-1:0] quot
);
   import orqm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_shift;
   logic [DEN_W:0]    diff;
   logic              fits;

   // Restoring divide, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, q_ff[NUM_W-1]};
      diff      = rem_shift - {1'b0, den_ff};
      fits      = !diff[DEN_W];

      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         q_in    = {q_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

### src/overwrite_ring_queue_with_mean.sv
// Insert passes through ST_READ, ST_START, ST_DIV and ST_DONE; its result waits on
//   the one-bit-per-cycle divider that forms the rounded mean.
// Remove passes through ST_READ (one registered read of the ring memory) and ST_DONE.
// One command in flight; a finished result may wait in the output register
//   while the next command is taken.
// Synchronous active-high reset empties the queue; ring contents are not cleared.
`default_nettype none

`include "overwrite_ring_queue_with_mean_macros.svh"

module overwrite_ring_queue_with_mean (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire orqm_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      orqm_pkg::rsp_type rsp_data
);
   import orqm_pkg::*;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   req_type            req_ff, req_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               mem_wr;
   logic               mem_rd;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic [NUM_W-1:0]   div_quot;
   logic [SUM_W-1:0]   old_ext;
   logic [SUM_W-1:0]   new_ext;
   logic [SUM_W-1:0]   sum_mag;
   logic [YEAR_W-1:0]  q_lo;

   // Ring storage
   assign wr_entry.tag  = req_ff.record_tag;
   assign wr_entry.year = req_ff.birth_year;

   orqm_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (mem_rd),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   // Rounded mean: (2*|sum| + n) / (2*n), sign applied afterwards
   assign sum_mag = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign div_num = {sum_mag, 1'b0} + NUM_W'(count_ff);
   assign div_den = {count_ff, 1'b0};

   orqm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign old_ext = {{(SUM_W-YEAR_W){rd_entry.year[YEAR_W-1]}}, rd_entry.year};
   assign new_ext = {{(SUM_W-YEAR_W){req_ff.birth_year[YEAR_W-1]}}, req_ff.birth_year};
   assign q_lo    = div_quot[YEAR_W-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      div_start    = 1'b0;
      req_ready    = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // take the command and fetch the head entry
            if (req_valid) begin
               req_in   = req_data;
               mem_rd   = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            res_in = '0;
            if (req_ff.action == ACT_INSERT) begin
               mem_wr             = 1'b1;
               res_in.result_kind = KIND_MEAN;
               tail_in            = next_ptr(tail_ff);
               if (count_ff == CNT_W'(DEPTH)) begin
                  // full: drop the oldest entry
                  res_in.evicted = 1'b1;
                  head_in        = next_ptr(head_ff);
                  sum_in         = sum_ff - old_ext + new_ext;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + new_ext;
               end
               state_in = ST_START;
            end else if (count_ff == '0) begin
               res_in.result_kind = KIND_EMPTY;
               state_in           = ST_DONE;
            end else begin
               res_in.result_kind  = KIND_REMOVED;
               res_in.removed_tag  = rd_entry.tag;
               res_in.removed_year = rd_entry.year;
               head_in             = next_ptr(head_ff);
               count_in            = count_ff - CNT_W'(1);
               sum_in              = sum_ff - old_ext;
               state_in            = ST_DONE;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_in.mean_year = sum_ff[SUM_W-1] ? -q_lo : q_lo;
               state_in         = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in           = res_ff;
               rsp_data_in.occupancy = OCC_W'(count_ff);
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `ORQM_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   `ORQM_ASSERT(a_busy_after_transfer, (req_valid && req_ready) |=> !req_ready, "ready during work")
   `ORQM_ASSERT(a_div_done_state, div_done |-> (state_ff == ST_DIV), "divider done out of step")
   `ORQM_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> $past(state_ff == ST_DONE), "stray result")

endmodule

`default_nettype wire

### sim/tb_overwrite_ring_queue_with_mean.sv
`timescale 1ns / 1ps

module tb_overwrite_ring_queue_with_mean;
   import orqm_pkg::*;

   localparam int RANDOM_CMDS  = 1424;
   localparam int CALM_CMDS    = 150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;

   // Ring queue predictor and pending result store
   class ring_queue_checker;
      logic [TAG_W-1:0] tag_ring [DEPTH];
      int               year_ring [DEPTH];
      int               head_idx;
      int               tail_idx;
      int               held;
      int               year_total;
      rsp_type          pending_results [$];
      int               mismatches;

      // Half away from zero
      function int rounded_mean(input int total, input int n);
         if (n == 0) return 0;
         if (total >= 0) return (total * 2 + n) / (2 * n);
         return -((-total * 2 + n) / (2 * n));
      endfunction

      // Note an accepted command and queue the result it must produce
      function void predict_command(input req_type cmd);
         rsp_type want;
         want = '0;
         if (cmd.action == ACT_INSERT) begin
            // full: drop the oldest before the append
            if (held >= DEPTH) begin
               year_total -= year_ring[head_idx];
               head_idx = (head_idx + 1) % DEPTH;
               held--;
               want.evicted = 1'b1;
            end
            tag_ring[tail_idx]  = cmd.record_tag;
            year_ring[tail_idx] = int'(cmd.birth_year);
            year_total += year_ring[tail_idx];
            tail_idx = (tail_idx + 1) % DEPTH;
            held++;
            want.result_kind = KIND_MEAN;
            want.mean_year   = YEAR_W'(rounded_mean(year_total, held));
         end else if (held == 0) begin
            want.result_kind = KIND_EMPTY;
         end else begin
            want.result_kind  = KIND_REMOVED;
            want.removed_tag  = tag_ring[head_idx];
            want.removed_year = YEAR_W'(year_ring[head_idx]);
            year_total -= year_ring[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
            held--;
         end
         want.occupancy = OCC_W'(held);
         pending_results.push_back(want);
      endfunction

      // Compare one result transfer against the oldest expectation
      function void check_result(input rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: kind %0d mean %0d ev %0d tag %h year %0d occ %0d",
                        got.result_kind, got.mean_year, got.evicted, got.removed_tag,
                        got.removed_year, got.occupancy);
            return;
         end
         want = pending_results.pop_front();
         if (got.result_kind !== want.result_kind || got.mean_year !== want.mean_year ||
             got.evicted !== want.evicted || got.removed_tag !== want.removed_tag ||
             got.removed_year !== want.removed_year || got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch: expected kind %0d mean %0d ev %0d tag %h year %0d occ %0d",
                        want.result_kind, want.mean_year, want.evicted, want.removed_tag,
                        want.removed_year, want.occupancy);
               $display("          actual   kind %0d mean %0d ev %0d tag %h year %0d occ %0d",
                        got.result_kind, got.mean_year, got.evicted, got.removed_tag,
                        got.removed_year, got.occupancy);
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;

   ring_queue_checker book;
   bit                calm = 1'b0;
   int                cycle_count = 0;

   overwrite_ring_queue_with_mean DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic req_type make_cmd(input logic act, input logic [TAG_W-1:0] tag,
                                        input logic signed [YEAR_W-1:0] year);
      req_type cmd;
      cmd.action     = act;
      cmd.record_tag = tag;
      cmd.birth_year = year;
      return cmd;
   endfunction

   // Mostly full-range years, some extremes, some small values for rounding ties
   function automatic logic signed [YEAR_W-1:0] pick_year();
      logic signed [YEAR_W-1:0] y;
      case ($urandom_range(0, 7))
         0:       y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1:       y = YEAR_W'($urandom_range(0, 6) - 3);
         default: y = YEAR_W'($urandom_range(0, 65535));
      endcase
      return y;
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      logic [TAG_W-1:0] t;
      case ($urandom_range(0, 15))
         0:       t = '0;
         1:       t = '1;
         default: t = $urandom();
      endcase
      return t;
   endfunction

   // Drive one command after an optional gap, hold until the transfer
   task automatic send_cmd(input req_type cmd, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.predict_command(cmd);
   endtask

   // Result side: bursts of stall within segments of varying pressure
   initial begin
      int stall_left;
      int seg_left;
      int stall_pct;
      rsp_ready  = 1'b0;
      stall_left = 0;
      seg_left   = 0;
      stall_pct  = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 200);
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 2;
               default: stall_pct = 6;
            endcase
         end
         seg_left--;
         if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 18);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         book.check_result(rsp_data);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Stimulus
   initial begin
      int seg_left;
      int insert_pct;
      int gap_pct;
      int gap;
      logic act;
      req_valid  = 1'b0;
      req_data   = '0;
      reset      = 1'b1;
      book       = new;
      seg_left   = 0;
      insert_pct = 50;
      gap_pct    = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: remove on empty, extremes, rounding ties, eviction, drain
      send_cmd(make_cmd(ACT_REMOVE, '1, 16'sh7fff), 0);
      send_cmd(make_cmd(ACT_INSERT, 32'hffff_ffff, 16'sh7fff), 0);
      send_cmd(make_cmd(ACT_INSERT, 32'h0000_0000, 16'sh8000), 0);
      send_cmd(make_cmd(ACT_INSERT, 32'h1234_5678, 16'sd1), 2);
      send_cmd(make_cmd(ACT_INSERT, 32'ha5a5_a5a5, 16'sd2), 0);
      repeat (3) send_cmd(make_cmd(ACT_REMOVE, '0, '0), 0);
      for (int i = 0; i <= DEPTH; i++)
         send_cmd(make_cmd(ACT_INSERT, TAG_W'(32'h8000_0000 + i), 16'sh8000), 0);
      repeat (DEPTH) send_cmd(make_cmd(ACT_REMOVE, '0, '0), 1);
      send_cmd(make_cmd(ACT_REMOVE, '1, '1), 0);

      // Random: insert-heavy, remove-heavy and balanced segments
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 30);
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 15;
               default: insert_pct = 50;
            endcase
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 30;
               default: gap_pct = 8;
            endcase
         end
         seg_left--;
         if (n >= RANDOM_CMDS - CALM_CMDS) calm = 1'b1;
         gap = 0;
         if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 18);
         act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
         send_cmd(make_cmd(act, pick_tag(), pick_year()), gap);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then let any stray result show up
      while (book.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
